// ----- hw/rtl/ebt_pkg.sv -----
// ----------------------------------------------------------------------------
// Error-rate ban table package
// Shared sizes, codes and the structs that run between the controller and
// the row of table cells.
// ----------------------------------------------------------------------------
package ebt_pkg;

	localparam int ENTRIES       = 64;
	localparam int ENTRY_W       = $clog2(ENTRIES);
	localparam int RANK_W        = ENTRY_W;
	localparam int NUM_W         = ENTRY_W + 1;
	localparam int MAX_THRESHOLD = 16;
	localparam int SLOT_W        = (MAX_THRESHOLD > 1) ? $clog2(MAX_THRESHOLD) : 1;
	localparam int CNT_W         = 5;
	localparam int EXPIRE_BATCH  = 4;
	localparam int BATCH_W       = (EXPIRE_BATCH > 1) ? $clog2(EXPIRE_BATCH) : 1;
	localparam int KEY_W         = 64;
	localparam int TIME_W        = 32;
	localparam int EV_ADDR_W     = ENTRY_W + SLOT_W;

	localparam logic [1:0] CMD_LOOKUP  = 2'd0;
	localparam logic [1:0] CMD_RECORD  = 2'd1;
	localparam logic [1:0] CMD_SOFTBAN = 2'd2;
	localparam logic [1:0] CMD_INVALID = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BLOCKED = 2'd1;
	localparam logic [1:0] ST_ERROR   = 2'd2;

	localparam logic [1:0] REG_THRESHOLD  = 2'd0;
	localparam logic [1:0] REG_INTERVAL   = 2'd1;
	localparam logic [1:0] REG_BLOCK_TIME = 2'd2;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		logic              expire_en;
		logic [RANK_W-1:0] tail_rank;
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] interval;
		logic [KEY_W-1:0]  key;
		logic              wr_en;
		logic [ENTRY_W-1:0] wr_idx;
		logic [NUM_W-1:0]  touch_rank;
		logic [TIME_W-1:0] wr_seen_at;
		logic [TIME_W-1:0] wr_ban_end;
		logic [CNT_W-1:0]  wr_cnt;
	} ebt_ccmd_t;

	// Status of one cell; hit_idx and the entry fields are zero unless the cell is hit, free_idx unless it takes.
	typedef struct packed {
		logic               valid;
		logic               hit;
		logic               take;
		logic               expired;
		logic [ENTRY_W-1:0] hit_idx;
		logic [ENTRY_W-1:0] free_idx;
		logic [TIME_W-1:0]  seen_at;
		logic [TIME_W-1:0]  ban_end;
		logic [CNT_W-1:0]   cnt;
		logic [RANK_W-1:0]  rank;
	} ebt_cstat_t;

endpackage

// ----- hw/rtl/ebt_evmem.sv -----
// ----------------------------------------------------------------------------
// Event timestamp memory
// One write port and one registered read port, one row of slots per entry.
// ----------------------------------------------------------------------------
module ebt_evmem (
	input  logic                          clk,
	input  logic                          we,
	input  logic [ebt_pkg::EV_ADDR_W-1:0] waddr,
	input  logic [ebt_pkg::TIME_W-1:0]    wdata,
	input  logic                          re,
	input  logic [ebt_pkg::EV_ADDR_W-1:0] raddr,
	output logic [ebt_pkg::TIME_W-1:0]    rdata
);

	logic [ebt_pkg::TIME_W-1:0] mem_q [2**ebt_pkg::EV_ADDR_W];
	logic [ebt_pkg::TIME_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/ebt_cell.sv -----
// ----------------------------------------------------------------------------
// Table cell
// Holds one tracker entry, matches keys, judges its own staleness at the LRU
// tail and passes the free-entry token on to its neighbor.
// ----------------------------------------------------------------------------
module ebt_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [ebt_pkg::ENTRY_W-1:0] idx,
	input  ebt_pkg::ebt_ccmd_t          cmd,
	input  logic                        free_in,
	output logic                        free_out,
	output ebt_pkg::ebt_cstat_t         stat
);

	logic                       valid_q;
	logic [ebt_pkg::KEY_W-1:0]  key_q;
	logic [ebt_pkg::TIME_W-1:0] ls_q;
	logic [ebt_pkg::TIME_W-1:0] ban_q;
	logic [ebt_pkg::CNT_W-1:0]  cnt_q;
	logic [ebt_pkg::RANK_W-1:0] rank_q;

	logic hit, take, stale, expired, sel;

	assign hit      = valid_q && (key_q == cmd.key);
	assign take     = !valid_q && !free_in;
	assign free_out = free_in || !valid_q;
	assign stale    = !(ban_q > cmd.now) && (cmd.now >= ls_q) &&
			((cmd.now - ls_q) >= cmd.interval);
	assign expired  = cmd.expire_en && valid_q && (rank_q == cmd.tail_rank) && stale;
	assign sel      = cmd.wr_en && (idx == cmd.wr_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (expired) begin
			valid_q <= 1'b0;
		end else if (sel) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (sel) begin
			key_q  <= cmd.key;
			ls_q   <= cmd.wr_seen_at;
			ban_q  <= cmd.wr_ban_end;
			cnt_q  <= cmd.wr_cnt;
			rank_q <= '0;
		end else if (cmd.wr_en && valid_q && ({1'b0, rank_q} < cmd.touch_rank)) begin
			rank_q <= rank_q + 1'b1;
		end
	end

	always_comb begin
		stat.valid     = valid_q;
		stat.hit       = hit;
		stat.take      = take;
		stat.expired   = expired;
		stat.hit_idx   = hit ? idx : '0;
		stat.free_idx  = take ? idx : '0;
		stat.seen_at   = hit ? ls_q : '0;
		stat.ban_end   = hit ? ban_q : '0;
		stat.cnt       = hit ? cnt_q : '0;
		stat.rank      = hit ? rank_q : '0;
	end

endmodule

// ----- hw/rtl/error_rate_ban_table.sv -----
// ----------------------------------------------------------------------------
// Error-rate ban table
// Sliding-window error tracker per key with LRU expiry and ban times.
// ----------------------------------------------------------------------------
// Usage: an item on the input channel (cmd, key, now, ttl) is taken when
// in_valid is high and in_stall is low. Each item yields exactly one result
// item (status, count, ban_expiry) on the output channel, taken when
// out_valid is high and out_stall is low.
// Steps: an item walks through a sequencer: tail expiry (at most
// EXPIRE_BATCH entries), a key search, a decision, a compaction pass of the
// window timestamps through the timestamp memory, an append (records only)
// and a write-back, then the result register. Softbans and active bans skip
// the compaction; a lookup miss or a full table ends after the decision, and
// rejected commands go straight to the result register.
// Throughput: one item at a time; the compaction loop over the memory port
// sets the worst case. The next item is taken while a result still waits in
// the output register.
// Reset clears every entry's valid bit and restores the registers to their
// defaults; no clearing pass is needed. A stalled receiver holds the result;
// the sequencer waits in its final state until the output register is free.
// Configuration writes are applied at once and must come while idle.
// ----------------------------------------------------------------------------
module error_rate_ban_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_addr,
	input  logic [ebt_pkg::TIME_W-1:0]  cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  cmd,
	input  logic [ebt_pkg::KEY_W-1:0]   key,
	input  logic [ebt_pkg::TIME_W-1:0]  now,
	input  logic [ebt_pkg::TIME_W-1:0]  ttl,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic [ebt_pkg::CNT_W-1:0]   count,
	output logic [ebt_pkg::TIME_W-1:0]  ban_expiry
);

	typedef enum logic [2:0] {
		S_IDLE, S_EXPIRE, S_FIND, S_DECIDE, S_PRUNE, S_POST, S_WB, S_DONE
	} state_t;

	localparam int TW = ebt_pkg::TIME_W;
	localparam int CW = ebt_pkg::CNT_W;

	// Saturating time sum.
	function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a,
			input logic [TW-1:0] b);
		logic [TW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TW] ? {TW{1'b1}} : s[TW-1:0];
	endfunction

	state_t state_q;

	// Configuration registers.
	logic [CW-1:0] thr_q;
	logic [TW-1:0] interval_q;
	logic [TW-1:0] block_q;
	logic [CW-1:0] thr_eff;

	// Latched item.
	logic [1:0]                 cmd_q;
	logic [ebt_pkg::KEY_W-1:0]  key_q;
	logic [TW-1:0]              now_q;
	logic [TW-1:0]              ttl_q;

	// Table bookkeeping.
	logic [ebt_pkg::NUM_W-1:0]   n_q;
	logic [ebt_pkg::BATCH_W-1:0] batch_q;

	// Search results.
	logic                        f_hit_q;
	logic                        f_free_q;
	logic [ebt_pkg::ENTRY_W-1:0] f_idx_q;
	logic [ebt_pkg::ENTRY_W-1:0] f_free_idx_q;
	logic [TW-1:0]               f_ban_q;
	logic [CW-1:0]               f_cnt_q;
	logic [ebt_pkg::RANK_W-1:0]  f_rank_q;

	// Working copy of the entry being changed.
	logic [ebt_pkg::ENTRY_W-1:0] e_q;
	logic [ebt_pkg::NUM_W-1:0]   touch_q;
	logic                        create_q;
	logic [TW-1:0]               w_ban_q;
	logic [CW-1:0]               w_cnt_q;

	// Compaction pass.
	logic [CW-1:0] rd_i_q;
	logic [CW-1:0] keep_q;
	logic          pend_s1;

	// Result and output registers.
	logic [1:0]    res_st_q;
	logic [CW-1:0] res_cnt_q;
	logic [TW-1:0] res_exp_q;
	logic          out_valid_q;
	logic [1:0]    status_q;
	logic [CW-1:0] count_q;
	logic [TW-1:0] exp_q;

	// Cell row.
	ebt_pkg::ebt_ccmd_t  ccmd;
	ebt_pkg::ebt_cstat_t cstat [ebt_pkg::ENTRIES];
	logic [ebt_pkg::ENTRIES:0] free_chain;

	// Gathered cell status.
	logic                        g_hit, g_expired;
	logic [ebt_pkg::ENTRY_W-1:0] g_idx, g_free_idx;
	logic [TW-1:0]               g_ban;
	logic [CW-1:0]               g_cnt;
	logic [ebt_pkg::RANK_W-1:0]  g_rank;
	logic [ebt_pkg::ENTRIES-1:0] valid_vec, hit_vec;

	// Event memory ports.
	logic                           ev_we, ev_re;
	logic [ebt_pkg::EV_ADDR_W-1:0]  ev_waddr, ev_raddr;
	logic [TW-1:0]                  ev_wdata, ev_rdata;

	logic in_acc;
	logic out_free;
	logic ts_keep;
	logic [TW-1:0] ban0;
	logic [CW-1:0] cnt0;
	logic [CW-1:0] c_inc;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign count     = count_q;
	assign ban_expiry = exp_q;

	// Threshold clamped to 1..MAX_THRESHOLD.
	always_comb begin
		if (thr_q == '0) begin
			thr_eff = CW'(1);
		end else if (thr_q > CW'(ebt_pkg::MAX_THRESHOLD)) begin
			thr_eff = CW'(ebt_pkg::MAX_THRESHOLD);
		end else begin
			thr_eff = thr_q;
		end
	end

	// Command broadcast to the cells.
	always_comb begin
		ccmd.expire_en    = (state_q == S_EXPIRE) && (n_q != '0);
		ccmd.tail_rank    = ebt_pkg::RANK_W'(n_q - 1'b1);
		ccmd.now          = now_q;
		ccmd.interval     = interval_q;
		ccmd.key          = key_q;
		ccmd.wr_en        = (state_q == S_WB);
		ccmd.wr_idx       = e_q;
		ccmd.touch_rank   = touch_q;
		ccmd.wr_seen_at   = now_q;
		ccmd.wr_ban_end   = w_ban_q;
		ccmd.wr_cnt       = w_cnt_q;
	end

	assign free_chain[0] = 1'b0;

	for (genvar i = 0; i < ebt_pkg::ENTRIES; i++) begin : g_cell
		ebt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (ebt_pkg::ENTRY_W'(i)),
			.cmd      (ccmd),
			.free_in  (free_chain[i]),
			.free_out (free_chain[i+1]),
			.stat     (cstat[i])
		);
	end

	always_comb begin
		g_hit      = 1'b0;
		g_expired  = 1'b0;
		g_idx      = '0;
		g_free_idx = '0;
		g_ban      = '0;
		g_cnt      = '0;
		g_rank     = '0;
		for (int i = 0; i < ebt_pkg::ENTRIES; i++) begin
			g_hit      = g_hit | cstat[i].hit;
			g_expired  = g_expired | cstat[i].expired;
			g_idx      = g_idx | cstat[i].hit_idx;
			g_free_idx = g_free_idx | cstat[i].free_idx;
			g_ban      = g_ban | cstat[i].ban_end;
			g_cnt      = g_cnt | cstat[i].cnt;
			g_rank     = g_rank | cstat[i].rank;
			valid_vec[i] = cstat[i].valid;
			hit_vec[i]   = cstat[i].hit;
		end
	end

	ebt_evmem u_evmem (
		.clk   (clk),
		.we    (ev_we),
		.waddr (ev_waddr),
		.wdata (ev_wdata),
		.re    (ev_re),
		.raddr (ev_raddr),
		.rdata (ev_rdata)
	);

	// A stored timestamp stays when ts + interval > now, with no wrap.
	assign ts_keep = ({1'b0, ev_rdata} + {1'b0, interval_q}) > {1'b0, now_q};

	assign ev_re    = (state_q == S_PRUNE) && (rd_i_q < w_cnt_q);
	assign ev_raddr = {e_q, rd_i_q[ebt_pkg::SLOT_W-1:0]};

	always_comb begin
		ev_we    = 1'b0;
		ev_waddr = {e_q, keep_q[ebt_pkg::SLOT_W-1:0]};
		ev_wdata = ev_rdata;
		if (state_q == S_PRUNE) begin
			ev_we = pend_s1 && ts_keep;
		end else if (state_q == S_POST) begin
			ev_we    = w_cnt_q < CW'(ebt_pkg::MAX_THRESHOLD);
			ev_waddr = {e_q, w_cnt_q[ebt_pkg::SLOT_W-1:0]};
			ev_wdata = now_q;
		end
	end

	// Entry view for record and softban: a new entry starts clean.
	assign ban0  = f_hit_q ? f_ban_q : '0;
	assign cnt0  = f_hit_q ? f_cnt_q : '0;
	assign c_inc = (w_cnt_q < CW'(ebt_pkg::MAX_THRESHOLD)) ? w_cnt_q + 1'b1 :
			CW'(ebt_pkg::MAX_THRESHOLD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			thr_q       <= CW'(10);
			interval_q  <= TW'(60);
			block_q     <= TW'(600);
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					ebt_pkg::REG_THRESHOLD:  thr_q      <= cfg_wdata[CW-1:0];
					ebt_pkg::REG_INTERVAL:   interval_q <= cfg_wdata;
					ebt_pkg::REG_BLOCK_TIME: block_q    <= cfg_wdata;
					default: ;
				endcase
			end

			// In the final state the output register is reloaded instead.
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						cmd_q   <= cmd;
						key_q   <= key;
						now_q   <= now;
						ttl_q   <= ttl;
						batch_q <= '0;
						if ((cmd != ebt_pkg::CMD_LOOKUP && cmd != ebt_pkg::CMD_RECORD &&
								cmd != ebt_pkg::CMD_SOFTBAN) ||
								(cmd == ebt_pkg::CMD_SOFTBAN && ttl == '0)) begin
							res_st_q  <= ebt_pkg::ST_ERROR;
							res_cnt_q <= '0;
							res_exp_q <= '0;
							state_q   <= S_DONE;
						end else begin
							state_q <= S_EXPIRE;
						end
					end
				end
				S_EXPIRE: begin
					if (n_q == '0 || !g_expired) begin
						state_q <= S_FIND;
					end else begin
						n_q <= n_q - 1'b1;
						if (batch_q == ebt_pkg::BATCH_W'(ebt_pkg::EXPIRE_BATCH - 1)) begin
							state_q <= S_FIND;
						end else begin
							batch_q <= batch_q + 1'b1;
						end
					end
				end
				S_FIND: begin
					f_hit_q      <= g_hit;
					f_free_q     <= free_chain[ebt_pkg::ENTRIES];
					f_idx_q      <= g_idx;
					f_free_idx_q <= g_free_idx;
					f_ban_q      <= g_ban;
					f_cnt_q      <= g_cnt;
					f_rank_q     <= g_rank;
					state_q      <= S_DECIDE;
				end
				S_DECIDE: begin
					rd_i_q  <= '0;
					keep_q  <= '0;
					pend_s1 <= 1'b0;
					if (cmd_q == ebt_pkg::CMD_LOOKUP) begin
						e_q      <= f_idx_q;
						touch_q  <= {1'b0, f_rank_q};
						create_q <= 1'b0;
						w_ban_q  <= f_ban_q;
						w_cnt_q  <= f_cnt_q;
						if (!f_hit_q) begin
							res_st_q  <= ebt_pkg::ST_OK;
							res_cnt_q <= '0;
							res_exp_q <= '0;
							state_q   <= S_DONE;
						end else if (f_ban_q > now_q) begin
							state_q <= S_WB;
						end else if (f_ban_q != '0) begin
							// Ban has run out: forget its history.
							w_ban_q <= '0;
							w_cnt_q <= '0;
							state_q <= S_WB;
						end else begin
							state_q <= S_PRUNE;
						end
					end else if (!f_hit_q && !f_free_q) begin
						res_st_q  <= ebt_pkg::ST_ERROR;
						res_cnt_q <= '0;
						res_exp_q <= '0;
						state_q   <= S_DONE;
					end else begin
						e_q      <= f_hit_q ? f_idx_q : f_free_idx_q;
						touch_q  <= f_hit_q ? {1'b0, f_rank_q} : n_q;
						create_q <= !f_hit_q;
						if (cmd_q == ebt_pkg::CMD_SOFTBAN) begin
							w_ban_q <= sat_add(now_q, ttl_q);
							w_cnt_q <= '0;
							state_q <= S_WB;
						end else if (ban0 > now_q) begin
							w_ban_q <= ban0;
							w_cnt_q <= cnt0;
							state_q <= S_WB;
						end else begin
							w_ban_q <= '0;
							w_cnt_q <= (ban0 != '0) ? '0 : cnt0;
							state_q <= S_PRUNE;
						end
					end
				end
				S_PRUNE: begin
					if (ev_re) begin
						rd_i_q <= rd_i_q + 1'b1;
					end
					pend_s1 <= ev_re;
					if (pend_s1 && ts_keep) begin
						keep_q <= keep_q + 1'b1;
					end
					if (!ev_re && !pend_s1) begin
						w_cnt_q <= keep_q;
						state_q <= (cmd_q == ebt_pkg::CMD_RECORD) ? S_POST : S_WB;
					end
				end
				S_POST: begin
					if (c_inc >= thr_eff) begin
						w_ban_q <= sat_add(now_q, block_q);
						w_cnt_q <= '0;
					end else begin
						w_cnt_q <= c_inc;
					end
					state_q <= S_WB;
				end
				S_WB: begin
					if (create_q) begin
						n_q <= n_q + 1'b1;
					end
					if (cmd_q == ebt_pkg::CMD_SOFTBAN) begin
						res_st_q  <= ebt_pkg::ST_OK;
						res_cnt_q <= '0;
						res_exp_q <= (w_ban_q > now_q) ? w_ban_q : '0;
					end else if (w_ban_q > now_q) begin
						res_st_q  <= ebt_pkg::ST_BLOCKED;
						res_cnt_q <= thr_eff;
						res_exp_q <= w_ban_q;
					end else begin
						res_st_q  <= ebt_pkg::ST_OK;
						res_cnt_q <= w_cnt_q;
						res_exp_q <= '0;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						status_q    <= res_st_q;
						count_q     <= res_cnt_q;
						exp_q       <= res_exp_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The entry count tracks the number of live cells.
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == n_q)
		else $error("entry count differs from live cells");

	// A key lives in at most one cell.
	a_unique_key: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec))
		else $error("key held by more than one cell");

	// A compaction pass never runs past a full row of timestamps.
	a_prune_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PRUNE |-> rd_i_q <= CW'(ebt_pkg::MAX_THRESHOLD))
		else $error("compaction index out of range");

	// Expiry only removes the tail while entries remain.
	a_expire_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		g_expired |-> n_q != '0)
		else $error("expiry with empty table");

endmodule

// ----- sim/error_rate_ban_table_tb.sv -----
// ----------------------------------------------------------------------------
// Error-rate ban table testbench
// Drives lookup, record, softban and invalid items with random gaps and
// receiver stalls, predicts every result with a behavioral table model and
// checks the results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Expected result of one command.
typedef struct {
	logic [1:0]  status;
	logic [4:0]  count;
	logic [31:0] ban_expiry;
} ban_result_t;

// Behavioral table model plus the queue of results it has predicted.
class ban_scoreboard;
	int unsigned threshold_r, interval_r, block_time_r;
	bit          valid [64];
	logic [63:0] ekey [64];
	logic [31:0] seen_at [64];
	logic [31:0] ban_end [64];
	int unsigned ev_cnt [64];
	logic [31:0] ev_time [64][16];
	int unsigned rank [64];
	ban_result_t pending[$];
	int          errors;

	function new();
		threshold_r = 10;
		interval_r = 60;
		block_time_r = 600;
		errors = 0;
		foreach (valid[i]) valid[i] = 0;
	endfunction

	function void set_reg(logic [1:0] idx, logic [31:0] v);
		case (idx)
			ebt_pkg::REG_THRESHOLD: threshold_r = v[4:0];
			ebt_pkg::REG_INTERVAL: interval_r = v;
			ebt_pkg::REG_BLOCK_TIME: block_time_r = v;
			default: ;
		endcase
	endfunction

	function logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function int unsigned thr();
		if (threshold_r < 1) return 1;
		if (threshold_r > 16) return 16;
		return threshold_r;
	endfunction

	function int unsigned used();
		int unsigned n;
		n = 0;
		foreach (valid[i]) if (valid[i]) n++;
		return n;
	endfunction

	// Drop stale entries from the LRU tail, at most four per command.
	function void expire_tail(logic [31:0] t);
		int unsigned n;
		int tl;
		for (int b = 0; b < ebt_pkg::EXPIRE_BATCH; b++) begin
			n = used();
			tl = -1;
			if (n == 0) return;
			for (int i = 0; i < 64; i++)
				if (valid[i] && rank[i] == n - 1) begin
					tl = i;
					break;
				end
			if (tl < 0) return;
			if (ban_end[tl] > t) return;
			if (t < seen_at[tl]) return;
			if (t - seen_at[tl] < interval_r) return;
			valid[tl] = 0;
		end
	endfunction

	function void touch(int e);
		for (int i = 0; i < 64; i++)
			if (valid[i] && rank[i] < rank[e]) rank[i]++;
		rank[e] = 0;
	endfunction

	function void prune(int e, logic [31:0] t);
		int unsigned keep;
		keep = 0;
		for (int i = 0; i < ev_cnt[e] && i < 16; i++)
			if ({1'b0, ev_time[e][i]} + {1'b0, interval_r[31:0]} > {1'b0, t}) begin
				ev_time[e][keep] = ev_time[e][i];
				keep++;
			end
		ev_cnt[e] = keep;
	endfunction

	function ban_result_t mk(logic [1:0] s, int unsigned c, logic [31:0] x);
		ban_result_t r;
		r.status = s;
		r.count = c[4:0];
		r.ban_expiry = x;
		return r;
	endfunction

	function ban_result_t banned_or_count(int e, logic [31:0] t);
		if (ban_end[e] > t) return mk(ebt_pkg::ST_BLOCKED, thr(), ban_end[e]);
		return mk(ebt_pkg::ST_OK, ev_cnt[e], 0);
	endfunction

	function ban_result_t predict(logic [1:0] c, logic [63:0] k, logic [31:0] t,
			logic [31:0] tl);
		int e;
		int unsigned n;
		e = -1;
		if (c == ebt_pkg::CMD_INVALID) return mk(ebt_pkg::ST_ERROR, 0, 0);
		if (c == ebt_pkg::CMD_SOFTBAN && tl == 0) return mk(ebt_pkg::ST_ERROR, 0, 0);
		expire_tail(t);
		for (int i = 0; i < 64; i++)
			if (valid[i] && ekey[i] == k) begin
				e = i;
				break;
			end
		if (c == ebt_pkg::CMD_LOOKUP) begin
			if (e < 0) return mk(ebt_pkg::ST_OK, 0, 0);
			touch(e);
			seen_at[e] = t;
			if (ban_end[e] > t) return banned_or_count(e, t);
			if (ban_end[e] != 0) begin
				ban_end[e] = 0;
				ev_cnt[e] = 0;
			end else prune(e, t);
			return mk(ebt_pkg::ST_OK, ev_cnt[e], 0);
		end
		if (e < 0) begin
			for (int i = 0; i < 64; i++)
				if (!valid[i]) begin
					e = i;
					break;
				end
			if (e < 0) return mk(ebt_pkg::ST_ERROR, 0, 0);
			for (int i = 0; i < 64; i++) if (valid[i]) rank[i]++;
			valid[e] = 1;
			ekey[e] = k;
			seen_at[e] = t;
			ban_end[e] = 0;
			ev_cnt[e] = 0;
			rank[e] = 0;
		end else begin
			touch(e);
			seen_at[e] = t;
		end
		if (c == ebt_pkg::CMD_SOFTBAN) begin
			ban_end[e] = sat_sum(t, tl);
			ev_cnt[e] = 0;
			return mk(ebt_pkg::ST_OK, 0, (ban_end[e] > t) ? ban_end[e] : 0);
		end
		if (ban_end[e] > t) return banned_or_count(e, t);
		if (ban_end[e] != 0) begin
			ban_end[e] = 0;
			ev_cnt[e] = 0;
		end
		prune(e, t);
		n = ev_cnt[e];
		if (n < 16) ev_time[e][n] = t;
		n++;
		if (n > 16) n = 16;
		ev_cnt[e] = n;
		if (n >= thr()) begin
			ban_end[e] = sat_sum(t, block_time_r);
			ev_cnt[e] = 0;
		end
		return banned_or_count(e, t);
	endfunction

	function void note_command(logic [1:0] c, logic [63:0] k, logic [31:0] t,
			logic [31:0] tl);
		pending.push_back(predict(c, k, t, tl));
	endfunction

	function void check_result(logic [1:0] s, logic [4:0] c, logic [31:0] x);
		ban_result_t w;
		if (pending.size() == 0) begin
			$error("result with no command pending: status %0d", s);
			errors++;
			return;
		end
		w = pending.pop_front();
		if (s !== w.status) begin
			$error("status: expected %0d, got %0d", w.status, s);
			errors++;
		end
		if (c !== w.count) begin
			$error("count: expected %0d, got %0d", w.count, c);
			errors++;
		end
		if (x !== w.ban_expiry) begin
			$error("ban_expiry: expected %0d, got %0d", w.ban_expiry, x);
			errors++;
		end
	endfunction
endclass

module error_rate_ban_table_tb;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_addr;
	logic [31:0] cfg_wdata;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  cmd;
	logic [63:0] key;
	logic [31:0] now;
	logic [31:0] ttl;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [4:0]  count;
	logic [31:0] ban_expiry;

	ban_scoreboard sb;
	// When set, the receiver stalls for a long stretch so the block backs up.
	bit          hold_receiver;
	bit          hold_done;
	// Running clock of the stimulus, so that time moves mostly forward.
	logic [31:0] clock_s;
	logic [63:0] key_pool [12];

	error_rate_ban_table uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata), .in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .key(key), .now(now), .ttl(ttl), .out_valid(out_valid),
		.out_stall(out_stall), .status(status), .count(count),
		.ban_expiry(ban_expiry)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Mostly short gaps with the occasional long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offer one item and hold it until the block takes it. The prediction
	// is made at the accepting edge, so it sees the table as the block does.
	// in_valid stays high afterwards; a gap or a drain lowers it.
	task automatic send_item(logic [1:0] c, logic [63:0] k, logic [31:0] t,
			logic [31:0] tl);
		in_valid <= 1'b1;
		cmd <= c;
		key <= k;
		now <= t;
		ttl <= tl;
		@(posedge clk iff !in_stall);
		sb.note_command(c, k, t, tl);
	endtask

	task automatic send_gapped(logic [1:0] c, logic [63:0] k, logic [31:0] t,
			logic [31:0] tl);
		int g;
		g = gap_len();
		if (g != 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		send_item(c, k, t, tl);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		sb.set_reg(idx, v);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Random command weighted toward records on a small set of keys, so
	// bans and window pruning are reached often.
	task automatic random_item();
		int r;
		logic [1:0]  c;
		logic [63:0] k;
		logic [31:0] tl;
		r = $urandom_range(0, 99);
		if (r < 30) c = ebt_pkg::CMD_LOOKUP;
		else if (r < 85) c = ebt_pkg::CMD_RECORD;
		else if (r < 97) c = ebt_pkg::CMD_SOFTBAN;
		else c = ebt_pkg::CMD_INVALID;
		if ($urandom_range(0, 9) < 8) k = key_pool[$urandom_range(0, 11)];
		else k = {$urandom, $urandom};
		r = $urandom_range(0, 99);
		if (r < 70) clock_s = clock_s + $urandom_range(0, 8);
		else if (r < 90) clock_s = clock_s + $urandom_range(20, 200);
		else if (r < 96) clock_s = clock_s - $urandom_range(0, 30);
		else clock_s = $urandom;
		r = $urandom_range(0, 9);
		if (r == 0) tl = 0;
		else if (r == 1) tl = $urandom;
		else tl = $urandom_range(1, 300);
		send_gapped(c, k, clock_s, tl);
	endtask

	// Receiver: random stalls, and one long hold-off on request.
	initial begin
		int g;
		out_stall = 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_receiver && !hold_done) begin
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				hold_done = 1'b1;
				out_stall <= 1'b0;
			end else begin
				g = gap_len();
				if (g != 0) begin
					out_stall <= 1'b1;
					repeat (g) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sb.check_result(status, count, ban_expiry);

	initial begin
		#4_000_000;
		$display("[error_rate_ban_table] ERROR");
		$finish;
	end

	initial begin
		sb = new();
		hold_receiver = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = ebt_pkg::REG_THRESHOLD;
		cfg_wdata = 32'd0;
		in_valid = 1'b0;
		cmd = ebt_pkg::CMD_LOOKUP;
		key = 64'd0;
		now = 32'd0;
		ttl = 32'd0;
		clock_s = 32'd1000;
		foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
		key_pool[0] = 64'd0;
		key_pool[1] = 64'hFFFF_FFFF_FFFF_FFFF;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: unknown key, errors, extremes, bans and expiry.
		send_item(ebt_pkg::CMD_LOOKUP, 64'd0, 32'd0, 32'd0);
		send_item(ebt_pkg::CMD_INVALID, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF);
		send_item(ebt_pkg::CMD_SOFTBAN, 64'd5, 32'd10, 32'd0);
		send_item(ebt_pkg::CMD_SOFTBAN, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFF0,
			32'hFFFF_FFFF);
		send_item(ebt_pkg::CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFF1, 32'd0);
		for (int i = 0; i < 10; i++)
			send_item(ebt_pkg::CMD_RECORD, 64'd7, 32'd100 + i, 0);
		send_item(ebt_pkg::CMD_RECORD, 64'd7, 32'd200, 32'd0);
		send_item(ebt_pkg::CMD_LOOKUP, 64'd7, 32'd800, 32'd0);
		send_item(ebt_pkg::CMD_LOOKUP, 64'd0, 32'd5000, 32'd0);
		drain();

		// Threshold 1, zero block time, wide window.
		write_reg(ebt_pkg::REG_THRESHOLD, 32'd1);
		write_reg(ebt_pkg::REG_BLOCK_TIME, 32'd0);
		write_reg(ebt_pkg::REG_INTERVAL, 32'hFFFF_FFFF);
		send_item(ebt_pkg::CMD_RECORD, 64'd9, 32'd6000, 32'd0);
		send_item(ebt_pkg::CMD_LOOKUP, 64'd9, 32'd6001, 32'd0);
		drain();

		// Out-of-range thresholds are clamped; fill the table past capacity.
		write_reg(ebt_pkg::REG_THRESHOLD, 32'd31);
		write_reg(ebt_pkg::REG_BLOCK_TIME, 32'hFFFF_FFFF);
		for (int i = 0; i < 66; i++)
			send_item(ebt_pkg::CMD_RECORD, 64'h100 + i, 32'd7000, 32'd0);
		drain();
		write_reg(ebt_pkg::REG_THRESHOLD, 32'd0);
		send_item(ebt_pkg::CMD_RECORD, 64'h100, 32'd7001, 32'd0);
		drain();

		// Random phases over several settings, with a long receiver hold
		// in the first one and a sender pause between phases.
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin
					write_reg(ebt_pkg::REG_THRESHOLD, 32'd3);
					write_reg(ebt_pkg::REG_INTERVAL, 32'd1);
					write_reg(ebt_pkg::REG_BLOCK_TIME, 32'd50);
				end
				1: begin
					write_reg(ebt_pkg::REG_THRESHOLD, 32'd16);
					write_reg(ebt_pkg::REG_INTERVAL, 32'd60);
					write_reg(ebt_pkg::REG_BLOCK_TIME, 32'd600);
				end
				2: begin
					write_reg(ebt_pkg::REG_THRESHOLD, $urandom_range(0, 31));
					write_reg(ebt_pkg::REG_INTERVAL, $urandom_range(1, 100));
					write_reg(ebt_pkg::REG_BLOCK_TIME, $urandom_range(0, 100));
				end
				default: begin
					write_reg(ebt_pkg::REG_THRESHOLD, 32'd5);
					write_reg(ebt_pkg::REG_INTERVAL, $urandom);
					write_reg(ebt_pkg::REG_BLOCK_TIME, $urandom);
				end
			endcase
			if (p == 0) hold_receiver = 1'b1;
			for (int i = 0; i < 140; i++) random_item();
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("[error_rate_ban_table] OK");
		else
			$display("[error_rate_ban_table] ERROR");
		$finish;
	end
endmodule
